FILE: rtl/afhd_pkg.sv
// Shared types and constants for the AFSK NRZI/HDLC bit decoder.
package afhd_pkg;

  localparam int unsigned NUM_DELTA_FIELDS = 5;
  localparam int unsigned MAX_DELTAS       = 5;
  localparam int unsigned DELTA_W          = 8;
  localparam int unsigned COUNT_W          = 4;
  localparam int unsigned THR_W            = 8;
  localparam int unsigned IN_TDATA_W       = 48;
  localparam int unsigned OUT_TDATA_W      = 16;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [2:0] FLAG_RUN  = 3'd6;
  localparam logic [2:0] STUFF_RUN = 3'd5;
  localparam logic [2:0] RUN_MAX   = 3'd7;
  localparam logic [2:0] LAST_BIT  = 3'd7;

  localparam logic [0:0] REG_SHORT_THR = 1'b0;
  localparam logic [0:0] REG_LONG_THR  = 1'b1;

  localparam logic [COUNT_W-1:0] MIN_COUNT = 4'd2;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_DELTAS);

  // Classification of one bit period, handed from the front to the back.
  typedef struct packed {
    logic invalid;
    logic any_short;
    logic any_long;
    logic any_mid;
  } period_cls_t;

  typedef struct packed {
    logic       carrier_detect;
    logic [7:0] byte_value;
    logic       byte_ready;
  } result_t;

endpackage

FILE: rtl/afhd_classify.sv
// Front end: sorts the zero-crossing intervals of one bit period into tone classes.
module afhd_classify
  import afhd_pkg::*;
(
  input  logic [IN_TDATA_W-1:0] tdata,
  input  logic [THR_W-1:0]      short_thr,
  input  logic [THR_W-1:0]      long_thr,
  output period_cls_t           cls
);

  logic [COUNT_W-1:0] count;
  logic [NUM_DELTA_FIELDS-1:0] is_short, is_long, is_mid;

  assign count = tdata[COUNT_W-1:0];

  always_comb begin
    for (int i = 0; i < NUM_DELTA_FIELDS; i++) begin
      logic [DELTA_W-1:0] d;
      logic               used;
      d    = tdata[COUNT_W + i*DELTA_W +: DELTA_W];
      used = (count > COUNT_W'(i));
      is_short[i] = used && (d < short_thr);
      is_long[i]  = used && (d > long_thr);
      is_mid[i]   = used && (d >= short_thr) && (d <= long_thr);
    end
    cls.invalid   = (count < MIN_COUNT) || (count > MAX_COUNT);
    cls.any_short = |is_short;
    cls.any_long  = |is_long;
    cls.any_mid   = |is_mid;
  end

endmodule

FILE: rtl/afhd_queue.sv
// Short queue of classified bit periods between the front and the back.
module afhd_queue
  import afhd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  period_cls_t push_data,
  output logic        full,
  input  logic        pop,
  output period_cls_t pop_data,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  period_cls_t        mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: rtl/afhd_decode.sv
// Back end: NRZI decoding, bit destuffing, flag detection and byte assembly.
module afhd_decode
  import afhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cls_valid,
  input  period_cls_t cls,
  output logic        cls_take,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  logic       line_level_r, line_level_nxt;
  logic [2:0] ones_run_r, ones_run_nxt;
  logic [7:0] partial_r, partial_nxt;
  logic [2:0] bit_pos_r, bit_pos_nxt;
  logic [7:0] last_byte_r, last_byte_nxt;
  logic       carrier_r, carrier_nxt;
  logic       res_valid_r;
  result_t    res_r, res_nxt;

  logic level, ambiguous, ready, stuffed;

  // The output register frees up when it is empty or its transfer completes.
  assign cls_take  = cls_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    line_level_nxt = line_level_r;
    ones_run_nxt   = ones_run_r;
    partial_nxt    = partial_r;
    bit_pos_nxt    = bit_pos_r;
    last_byte_nxt  = last_byte_r;
    carrier_nxt    = carrier_r;
    ready          = 1'b0;
    stuffed        = 1'b0;

    ambiguous = cls.any_mid || (cls.any_short && cls.any_long);
    level     = ambiguous ? !line_level_r : cls.any_short;

    if (cls.invalid) begin
      line_level_nxt = 1'b0;
      ones_run_nxt   = '0;
      partial_nxt    = '0;
      bit_pos_nxt    = '0;
      carrier_nxt    = 1'b0;
    end else begin
      carrier_nxt = 1'b1;
      if (level != line_level_r) begin
        if (ones_run_r >= FLAG_RUN) begin
          partial_nxt = FLAG_BYTE;
          bit_pos_nxt = LAST_BIT;
        end else if (ones_run_r == STUFF_RUN) begin
          stuffed = 1'b1;
        end
        ones_run_nxt = '0;
      end else begin
        if (ones_run_r < RUN_MAX) ones_run_nxt = ones_run_r + 1'b1;
        partial_nxt = partial_r | (8'h01 << bit_pos_r);
      end

      if (stuffed) begin
        // A stuffed zero is dropped; only the level tracks it.
        line_level_nxt = level;
      end else begin
        if (cls.any_short || cls.any_long) line_level_nxt = level;
        if (bit_pos_nxt < LAST_BIT) begin
          bit_pos_nxt = bit_pos_nxt + 1'b1;
        end else begin
          last_byte_nxt = partial_nxt;
          partial_nxt   = '0;
          bit_pos_nxt   = '0;
          ready         = 1'b1;
        end
      end
    end

    res_nxt.byte_ready     = ready;
    res_nxt.byte_value     = last_byte_nxt;
    res_nxt.carrier_detect = carrier_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_level_r <= 1'b0;
      ones_run_r   <= '0;
      partial_r    <= '0;
      bit_pos_r    <= '0;
      last_byte_r  <= '0;
      carrier_r    <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      if (cls_take) begin
        line_level_r <= line_level_nxt;
        ones_run_r   <= ones_run_nxt;
        partial_r    <= partial_nxt;
        bit_pos_r    <= bit_pos_nxt;
        last_byte_r  <= last_byte_nxt;
        carrier_r    <= carrier_nxt;
        res_valid_r  <= 1'b1;
      end else if (res_ready) begin
        res_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_take) res_r <= res_nxt;
  end

endmodule

FILE: rtl/afsk_nrzi_hdlc_bit_decoder.sv
// Top level of the AFSK NRZI/HDLC bit decoder: classifier, queue and decoder.
//
//   Channel | Direction | Contents
//   in_     | slave     | one bit period: delta count and five zero-crossing intervals
//   out_    | master    | byte ready flag, last completed byte, carrier detect
//   cfg_    | write     | short threshold (index 0), long threshold (index 1)
//
// One bit period is accepted per cycle while in_tready is high; its result is loaded
// into the output register when the decoder takes it from the queue.
// Reset is synchronous and active low and brings back the default thresholds.
// A stalled output fills the queue, and then in_tready drops until space returns.
module afsk_nrzi_hdlc_bit_decoder
  import afhd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] delta_count, [11:4] delta_0, [19:12] delta_1, [27:20] delta_2,
  // [35:28] delta_3, [43:36] delta_4, [47:44] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] byte_ready, [8:1] byte_value, [9] carrier_detect, [15:10] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_addr,
  input  logic [THR_W-1:0]       cfg_wdata
);

  logic [THR_W-1:0] short_thr_r, long_thr_r;
  period_cls_t      front_cls, back_cls;
  logic             q_full, q_empty, q_pop;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_thr_r <= 8'd8;
      long_thr_r  <= 8'd12;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHORT_THR: short_thr_r <= cfg_wdata;
        REG_LONG_THR:  long_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;

  afhd_classify u_classify (
    .tdata     (in_tdata),
    .short_thr (short_thr_r),
    .long_thr  (long_thr_r),
    .cls       (front_cls)
  );

  afhd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_cls),
    .empty     (q_empty)
  );

  afhd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (!q_empty),
    .cls       (back_cls),
    .cls_take  (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'b0, res.carrier_detect, res.byte_value, res.byte_ready};

endmodule
